// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property shorthands, disabled while the active-high reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/msfe_pkg.sv
// ----------------------------------------------------------------------------
// Shape function package
// Shared widths, the per-stage control word and node numbering helpers.
// ----------------------------------------------------------------------------
package msfe_pkg;

  localparam int NUM_AXES = 3;
  localparam int ETA_W    = 16;
  localparam int OUT_W    = 15;
  localparam int NODE_W   = 3;
  localparam int DIM_W    = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

  // Control word that travels with one node down the lanes.
  typedef struct packed {
    logic                           valid;
    logic [NODE_W-1:0]              node;
    logic [DIM_W-1:0]               dim;
    logic [NUM_AXES-1:0][ETA_W-1:0] eta;
  } stage_t;

  // Corner sign bit of a node on one axis (1 means +1). The first axis uses
  // the Gray-style rule so that nodes run around the face in order.
  function automatic logic corner_bit(input logic [NODE_W-1:0] node, input int axis);
    logic b;
    if (axis == 0) begin
      b = node[0] ^ node[1];
    end else begin
      b = node[axis];
    end
    return b;
  endfunction

  // Number of the final node of an element of the given dimension.
  function automatic logic [NODE_W-1:0] last_node_of(input logic [DIM_W-1:0] dim);
    logic [NODE_W:0] cnt;
    cnt = (NODE_W+1)'(1) << dim;
    return NODE_W'(cnt - (NODE_W+1)'(1));
  endfunction

endpackage

// File: src/msfe_if.sv
// ----------------------------------------------------------------------------
// Shape function channels
// Valid/ready channels for the input point and for the per-node results.
// ----------------------------------------------------------------------------
interface msfe_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] eta_0;
  logic signed [15:0] eta_1;
  logic signed [15:0] eta_2;

  modport source (output valid, output eta_0, output eta_1, output eta_2, input ready);
  modport sink   (input valid, input eta_0, input eta_1, input eta_2, output ready);
endinterface

interface msfe_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         node_index;
  logic [14:0]        shape_value;
  logic signed [14:0] grad_0;
  logic signed [14:0] grad_1;
  logic signed [14:0] grad_2;
  logic               last_node;

  modport source (output valid, output node_index, output shape_value, output grad_0,
                  output grad_1, output grad_2, output last_node, input ready);
  modport sink   (input valid, input node_index, input shape_value, input grad_0,
                  input grad_1, input grad_2, input last_node, output ready);
endinterface

// File: src/msfe_lane.sv
// ----------------------------------------------------------------------------
// Shape function lane
// One product chain, one registered multiply per axis.
// ----------------------------------------------------------------------------
module msfe_lane
  import msfe_pkg::*;
#(
  parameter int MAX_DIM   = 3,
  parameter int FRAC_BITS = 14,
  parameter int VAL_W     = 22,
  parameter int FACT_W    = 17,
  parameter int LANE      = 0
) (
  input  logic                    clk,
  input  logic                    adv,
  input  stage_t                  ctl [MAX_DIM],
  output logic signed [VAL_W-1:0] val
);

  // Lane 0 forms the shape value; lane k+1 replaces factor k by its sign.
  localparam logic signed [VAL_W-1:0]  ONE_V = VAL_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [FACT_W-1:0] ONE_F = FACT_W'(64'sd1 <<< FRAC_BITS);

  logic signed [VAL_W-1:0] v [MAX_DIM+1];

  assign v[0] = ONE_V >>> ctl[0].dim;

  for (genvar p = 0; p < MAX_DIM; p++) begin : g_step
    logic                          s;
    logic signed [FACT_W-1:0]      eta_x;
    logic signed [FACT_W-1:0]      fac;
    logic signed [VAL_W+FACT_W-1:0] prod;
    logic signed [VAL_W-1:0]       nxt;

    always_comb begin
      s     = corner_bit(ctl[p].node, p);
      eta_x = FACT_W'($signed(ctl[p].eta[p]));
      if (LANE == p + 1) begin
        fac = s ? ONE_F : -ONE_F;
      end else begin
        fac = s ? (ONE_F + eta_x) : (ONE_F - eta_x);
      end
      prod = v[p] * fac;
      // Arithmetic shift floors toward minus infinity.
      if (ctl[p].dim > DIM_W'(p)) begin
        nxt = VAL_W'(prod >>> FRAC_BITS);
      end else begin
        nxt = v[p];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v[p+1] <= nxt;
      end
    end
  end

  assign val = v[MAX_DIM];

endmodule

// File: src/msfe_merge.sv
// ----------------------------------------------------------------------------
// Shape function merge
// Saturates the lane results and holds them in the result register.
// ----------------------------------------------------------------------------
module msfe_merge
  import msfe_pkg::*;
#(
  parameter int MAX_DIM   = 3,
  parameter int FRAC_BITS = 14,
  parameter int VAL_W     = 22
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  stage_t                  ctl,
  input  logic signed [VAL_W-1:0] lane_val [MAX_DIM+1],
  msfe_result_if.source           result
);

  localparam logic signed [VAL_W-1:0] ONE_V  = VAL_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [VAL_W-1:0] HALF_V = VAL_W'(64'sd1 <<< (FRAC_BITS - 1));

  logic        [OUT_W-1:0] shape_next;
  logic signed [OUT_W-1:0] grad_next [NUM_AXES];

  always_comb begin
    if (lane_val[0] < 0) begin
      shape_next = '0;
    end else if (lane_val[0] > ONE_V) begin
      shape_next = OUT_W'(ONE_V);
    end else begin
      shape_next = OUT_W'(lane_val[0]);
    end
  end

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_grad
    if (k < MAX_DIM) begin : g_used
      always_comb begin
        if (ctl.dim <= DIM_W'(k)) begin
          grad_next[k] = '0;
        end else if (lane_val[k+1] < -HALF_V) begin
          grad_next[k] = OUT_W'(-HALF_V);
        end else if (lane_val[k+1] > HALF_V) begin
          grad_next[k] = OUT_W'(HALF_V);
        end else begin
          grad_next[k] = OUT_W'(lane_val[k+1]);
        end
      end
    end else begin : g_unused
      assign grad_next[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.node_index  <= ctl.node;
      result.shape_value <= shape_next;
      result.grad_0      <= grad_next[0];
      result.grad_1      <= grad_next[1];
      result.grad_2      <= grad_next[2];
      result.last_node   <= (ctl.node == last_node_of(ctl.dim));
    end
  end

endmodule

// File: src/multilinear_shape_function_eval.sv
// ----------------------------------------------------------------------------
// Multilinear shape function evaluator
// Shape values and gradients of a 1-, 2- or 3-D hypercube element, per node.
// ----------------------------------------------------------------------------
//
//   channel   | direction | one request carries
//   ----------+-----------+----------------------------------------------------
//   point     | in        | eta_0, eta_1, eta_2 (Q2.14 natural coordinates)
//   result    | out       | node_index, shape_value, grad_0..2, last_node
//   cfg_wr_*  | in        | dimension register (write only)
//
// One point request yields 2^d result requests, one per clock while the
// result channel does not stall, issued by the node sequencer. A node
// passes through one lane register per axis and then the result register.
// Reset (rst, synchronous) empties the pipeline and sets the dimension to
// 3. A stall on the result channel freezes the whole pipeline; the next
// point is taken in the cycle its predecessor issues its final node.
//
module multilinear_shape_function_eval
  import msfe_pkg::*;
#(
  parameter int MAX_DIM   = 3,
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [DIM_W-1:0] cfg_wr_data,
  msfe_point_if.sink       point,
  msfe_result_if.source    result
);

  // A factor is one plus or minus a coordinate; a product grows by at most
  // GROW bits per axis before the final saturation.
  localparam int FACT_W = ((FRAC_BITS > ETA_W - 1) ? FRAC_BITS : ETA_W - 1) + 2;
  localparam int GROW   = FACT_W - 1 - FRAC_BITS;
  localparam int RAW_W  = FRAC_BITS + MAX_DIM * GROW + 2;
  localparam int VAL_W  = (RAW_W > OUT_W + 1) ? RAW_W : OUT_W + 1;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] dimension;
  logic [DIM_W-1:0] dim_eff;

  // The point under issue and the node it is on.
  logic                           item_valid;
  logic [DIM_W-1:0]               item_dim;
  logic [NUM_AXES-1:0][ETA_W-1:0] item_eta;
  logic [NODE_W-1:0]              node;

  logic   adv;
  logic   issue_last;
  logic   accept;
  stage_t st [MAX_DIM+1];
  logic signed [VAL_W-1:0] lane_val [MAX_DIM+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dimension <= cfg_wr_data;
    end
  end

  // A dimension of zero acts as one; anything above MAX_DIM acts as MAX_DIM.
  always_comb begin
    if (dimension == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dimension > MAX_DIM_C) begin
      dim_eff = MAX_DIM_C;
    end else begin
      dim_eff = dimension;
    end
  end

  // The pipeline moves whenever the result register is free or being read.
  assign adv         = !result.valid || result.ready;
  assign issue_last  = (node == last_node_of(item_dim));
  assign point.ready = !item_valid || (adv && issue_last);
  assign accept      = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      node       <= '0;
    end else if (accept) begin
      item_valid <= 1'b1;
      node       <= '0;
    end else if (adv && item_valid) begin
      if (issue_last) begin
        item_valid <= 1'b0;
      end else begin
        node <= node + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_dim <= dim_eff;
      item_eta <= {point.eta_2, point.eta_1, point.eta_0};
    end
  end

  assign st[0] = '{valid: item_valid, node: node, dim: item_dim, eta: item_eta};

  // Control words follow the lane registers one stage per axis.
  for (genvar p = 1; p <= MAX_DIM; p++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        st[p].valid <= 1'b0;
      end else if (adv) begin
        st[p].valid <= st[p-1].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[p].node <= st[p-1].node;
        st[p].dim  <= st[p-1].dim;
        st[p].eta  <= st[p-1].eta;
      end
    end
  end

  // Lane 0 gives the shape value, lane k+1 the gradient along axis k.
  for (genvar l = 0; l <= MAX_DIM; l++) begin : g_lane
    msfe_lane #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS),
      .VAL_W     (VAL_W),
      .FACT_W    (FACT_W),
      .LANE      (l)
    ) u_lane (
      .clk (clk),
      .adv (adv),
      .ctl (st[0:MAX_DIM-1]),
      .val (lane_val[l])
    );
  end

  msfe_merge #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .VAL_W     (VAL_W)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .ctl      (st[MAX_DIM]),
    .lane_val (lane_val),
    .result   (result)
  );

endmodule

// File: src/msfe_checker.sv
// ----------------------------------------------------------------------------
// Shape function checker
// Port-level checks on the result stream of the evaluator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  node_index,
  input logic [14:0] shape_value,
  input logic        last_node
);

  // Node number the next result request must carry.
  logic [2:0] exp_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_node <= '0;
    end else if (out_valid && out_ready) begin
      exp_node <= last_node ? 3'd0 : node_index + 3'd1;
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(node_index) && $stable(shape_value) && $stable(last_node))
  `ASSERT_IMPLY(a_order, clk, rst, out_valid, node_index == exp_node)
  `ASSERT_IMPLY(a_last, clk, rst, out_valid && last_node, node_index == 3'd1 || node_index == 3'd3 || node_index == 3'd7)

endmodule

bind multilinear_shape_function_eval msfe_checker u_msfe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .node_index  (result.node_index),
  .shape_value (result.shape_value),
  .last_node   (result.last_node)
);
